// ===== rtl/rgw_pkg.sv =====
package rgw_pkg;

	// Grid geometry. MAP_SIZE is a power of two.
	localparam int MAP_SIZE = 2048;
	localparam int MAP_W = $clog2(MAP_SIZE);

	// Register and datapath widths.
	localparam int CFG_W = 31;
	localparam int SPAN_W = CFG_W + MAP_W;
	localparam int AW = 48;
	localparam int BW = 17;
	localparam int PW = AW + BW;
	localparam int RW = PW + 1;
	localparam int OW = 36;

	// Reset values.
	localparam logic [CFG_W-1:0] CELL_SIZE_RST = 31'd6554;
	localparam logic [CFG_W-1:0] CPM_RST = 31'd655360;
	localparam logic signed [31:0] POSE_RST = 32'((MAP_SIZE / 2) * 6554);
	localparam logic signed [31:0] CELL_RST = 32'((MAP_SIZE / 2) * 65536);
	localparam logic signed [15:0] COS_RST = 16'sd16384;

	// Opcodes.
	localparam logic [2:0] OP_UPDATE = 3'd0;
	localparam logic [2:0] OP_PT_CELL = 3'd1;
	localparam logic [2:0] OP_PT_MAP = 3'd2;
	localparam logic [2:0] OP_OFS_MAP = 3'd3;
	localparam logic [2:0] OP_OFS_EGO = 3'd4;
	localparam logic [2:0] OP_CELL_EGO = 3'd5;
	localparam logic [2:0] OP_OFS_M = 3'd6;

	// Register indexes.
	localparam logic [0:0] REG_CELL_SIZE = 1'b0;
	localparam logic [0:0] REG_CPM = 1'b1;

	typedef struct packed {
		logic [2:0] opcode;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] rot_cos;
		logic signed [15:0] rot_sin;
		logic [10:0] cell_row;
		logic [10:0] cell_col;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic [10:0] row_stripe_start;
		logic [11:0] row_stripe_count;
		logic row_stripe_down;
		logic [10:0] col_stripe_start;
		logic [11:0] col_stripe_count;
		logic col_stripe_down;
		logic full_reset;
	} result_t;

	typedef struct packed {
		logic [10:0] start;
		logic [11:0] count;
		logic down;
	} stripe_t;

	typedef struct packed {
		logic start;
		logic signed [31:0] value;
		logic [SPAN_W-1:0] span;
	} mod_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] rem;
	} mod_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ROT, S_HALF, S_MQ, S_STRIPE, S_MOD, S_COMMIT,
		S_POST, S_ROUND, S_OFS, S_SAT, S_FIN, S_DONE
	} state_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
		logic [RW-32:0] upper;
		begin
			upper = v[RW-1:31];
			if ((&upper) || !(|upper)) begin
				return v[31:0];
			end
			return v[RW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
	endfunction

endpackage

// ===== rtl/rolling_grid_window_index.sv =====
// One item at a time; the next transfer is taken once the sequencer is idle.
// The pose update is dominated by two 32-step runs of the remainder unit, the rest by the
// shared 48x17 multiplier, one partial product per cycle.
// Reset (arst_n low) restores the default registers and the centred identity pose.
module rolling_grid_window_index (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  rgw_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output rgw_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [rgw_pkg::CFG_W-1:0]     cell_size_q;
	logic [rgw_pkg::CFG_W-1:0]     cpm_q;
	logic signed [rgw_pkg::AW-1:0] mul_a;
	logic signed [rgw_pkg::BW-1:0] mul_b;
	logic signed [rgw_pkg::PW-1:0] prod;
	rgw_pkg::mod_req_t             mod_req;
	rgw_pkg::mod_rsp_t             mod_rsp;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= rgw_pkg::CELL_SIZE_RST;
			cpm_q <= rgw_pkg::CPM_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2:2])
				rgw_pkg::REG_CELL_SIZE: cell_size_q <= pwdata[30:0];
				rgw_pkg::REG_CPM: cpm_q <= pwdata[30:0];
				default: cpm_q <= cpm_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2:2])
			rgw_pkg::REG_CELL_SIZE: prdata = {1'b0, cell_size_q};
			rgw_pkg::REG_CPM: prdata = {1'b0, cpm_q};
			default: prdata = '0;
		endcase
	end

	rgw_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.cell_size       (cell_size_q),
		.cells_per_metre (cpm_q),
		.mul_a           (mul_a),
		.mul_b           (mul_b),
		.prod            (prod),
		.mod_req         (mod_req),
		.mod_rsp         (mod_rsp)
	);

	rgw_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	rgw_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

endmodule

// ===== rtl/rgw_mul.sv =====
module rgw_mul (
	input  logic                          clk,
	input  logic signed [rgw_pkg::AW-1:0] a,
	input  logic signed [rgw_pkg::BW-1:0] b,
	output logic signed [rgw_pkg::PW-1:0] prod_q
);

	// Shared signed multiplier with its product registered.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ===== rtl/rgw_mod.sv =====
module rgw_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  rgw_pkg::mod_req_t  req,
	output rgw_pkg::mod_rsp_t  rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [4:0]                 cnt_q;
	logic [rgw_pkg::SPAN_W-1:0] rem_q;
	logic [rgw_pkg::SPAN_W-1:0] span_q;
	logic [31:0]                dvd_q;
	logic                       neg_q;
	logic [rgw_pkg::SPAN_W:0]   rem_sh;
	logic                       ge;
	logic [rgw_pkg::SPAN_W-1:0] diff;

	// One restoring step a cycle: shift in a dividend bit, subtract when it fits.
	assign rem_sh = {rem_q, dvd_q[31]};
	assign ge = rem_sh >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.value[31];
			dvd_q <= req.value[31] ? 32'(-req.value) : 32'(req.value);
			rem_q <= '0;
			span_q <= req.span;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= ge ? rgw_pkg::SPAN_W'(rem_sh - {1'b0, span_q})
			            : rgw_pkg::SPAN_W'(rem_sh);
		end
	end

	// Fold the truncated remainder into [0, span) and saturate.
	assign diff = span_q - rem_q;

	always_comb begin
		rsp.done = done_q;
		if (span_q == '0) begin
			rsp.rem = '0;
		end else if (neg_q && rem_q != '0) begin
			rsp.rem = (|diff[rgw_pkg::SPAN_W-1:31]) ? 32'sh7FFFFFFF : diff[31:0];
		end else begin
			rsp.rem = rem_q[31:0];
		end
	end

endmodule

// ===== rtl/rgw_core.sv =====
module rgw_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  rgw_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output rgw_pkg::result_t                 result,
	input  logic [rgw_pkg::CFG_W-1:0]        cell_size,
	input  logic [rgw_pkg::CFG_W-1:0]        cells_per_metre,
	output logic signed [rgw_pkg::AW-1:0]    mul_a,
	output logic signed [rgw_pkg::BW-1:0]    mul_b,
	input  logic signed [rgw_pkg::PW-1:0]    prod,
	output rgw_pkg::mod_req_t                mod_req,
	input  rgw_pkg::mod_rsp_t                mod_rsp
);

	localparam logic signed [rgw_pkg::OW-1:0] OFS_H =
		rgw_pkg::OW'((rgw_pkg::MAP_SIZE / 2) * 65536);
	localparam logic signed [rgw_pkg::OW-1:0] OFS_FULL =
		rgw_pkg::OW'(rgw_pkg::MAP_SIZE * 65536);

	rgw_pkg::state_t state_q, state_d;
	logic [3:0]  step_q;
	logic [3:0]  step_m1;
	rgw_pkg::item_t in_q;
	rgw_pkg::result_t res_q, out_q;
	rgw_pkg::result_t res_init;
	logic        out_valid_q;
	logic        out_free;
	logic        accept;
	logic        jump;
	logic [2:0]  mq_n_q;
	logic        mq_cs_q;
	logic        rot_map_q;
	logic        mod_sel_q;
	logic [rgw_pkg::CFG_W-1:0] mq_b;

	logic signed [rgw_pkg::AW-1:0] ux_q, uy_q, rx_q, ry_q;
	logic signed [rgw_pkg::AW-1:0] mq_a_q [4];
	logic signed [rgw_pkg::RW-1:0] mq_r_q [4];
	logic signed [rgw_pkg::PW-1:0] t_q;

	logic signed [31:0] last_pose_x_q, last_pose_y_q;
	logic signed [31:0] last_cell_x_q, last_cell_y_q;
	logic signed [15:0] last_cos_q, last_sin_q;

	logic [rgw_pkg::SPAN_W-1:0]    span;
	logic signed [rgw_pkg::SPAN_W+1:0] span_s, vx_e, vy_e;
	logic signed [rgw_pkg::PW:0]   t_minus_p, t_plus_p, p_minus_t;
	logic signed [rgw_pkg::RW-1:0] mq_sum;
	logic signed [rgw_pkg::AW-1:0] half_p, half_x, half_y, mx, my;
	logic                          x_pos, x_neg, y_pos, y_neg;
	logic signed [rgw_pkg::OW-1:0] ox, oy;
	rgw_pkg::stripe_t              stripe_x, stripe_y;

	// Stripe of one axis from the scaled begin and end positions.
	function automatic rgw_pkg::stripe_t stripe_fn(
		input logic signed [rgw_pkg::RW-1:0] rb,
		input logic signed [rgw_pkg::RW-1:0] re,
		input logic pos,
		input logic neg
	);
		logic signed [rgw_pkg::RW-1:0] bb, ee;
		logic signed [rgw_pkg::RW:0]   d, c;
		rgw_pkg::stripe_t              s;
		begin
			bb = rb >>> 16;
			ee = re >>> 16;
			d = (rgw_pkg::RW+1)'(ee) - (rgw_pkg::RW+1)'(bb);
			c = '0;
			if (pos && d > 0) begin
				c = d;
			end else if (neg && d < 0) begin
				c = -d;
			end
			if (c > (rgw_pkg::RW+1)'(rgw_pkg::MAP_SIZE)) begin
				c = (rgw_pkg::RW+1)'(rgw_pkg::MAP_SIZE);
			end
			s = '0;
			if (c != '0) begin
				s.start = 11'(bb & rgw_pkg::RW'(rgw_pkg::MAP_SIZE - 1));
				s.count = c[11:0];
				s.down = neg;
			end
			return s;
		end
	endfunction

	// Ego-centred offset of a wrapped cell index, Q16.16 cells.
	function automatic logic signed [rgw_pkg::OW-1:0] ofs_fn(
		input logic [10:0] idx,
		input logic signed [31:0] lastc
	);
		logic signed [rgw_pkg::OW-1:0] v;
		begin
			v = rgw_pkg::OW'({1'b0, idx, 16'b0}) - rgw_pkg::OW'(lastc);
			if (v > OFS_H) begin
				v = v - OFS_FULL;
			end else if (v < -OFS_H) begin
				v = v + OFS_FULL;
			end
			return v;
		end
	endfunction

	// Round half away from zero to whole cells, then wrap.
	function automatic logic [31:0] round_wrap(input logic signed [rgw_pkg::RW-1:0] q);
		logic signed [rgw_pkg::RW:0] qa, r;
		begin
			qa = q[rgw_pkg::RW-1] ? -(rgw_pkg::RW+1)'(q) : (rgw_pkg::RW+1)'(q);
			qa = qa + (rgw_pkg::RW+1)'(32768);
			r = qa >>> 16;
			if (q[rgw_pkg::RW-1]) begin
				r = -r;
			end
			return 32'(r & (rgw_pkg::RW+1)'(rgw_pkg::MAP_SIZE - 1));
		end
	endfunction

	// Shared arithmetic helpers.
	assign accept = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign span = {cell_size, {rgw_pkg::MAP_W{1'b0}}};
	assign span_s = (rgw_pkg::SPAN_W+2)'({2'b0, span});
	assign vx_e = (rgw_pkg::SPAN_W+2)'($signed(item.vec_x));
	assign vy_e = (rgw_pkg::SPAN_W+2)'($signed(item.vec_y));
	assign jump = (vx_e > span_s) || (vx_e < -span_s) || (vy_e > span_s) || (vy_e < -span_s);
	assign step_m1 = step_q - 4'd1;
	assign t_minus_p = (rgw_pkg::PW+1)'(t_q) - (rgw_pkg::PW+1)'(prod);
	assign t_plus_p = (rgw_pkg::PW+1)'(t_q) + (rgw_pkg::PW+1)'(prod);
	assign p_minus_t = (rgw_pkg::PW+1)'(prod) - (rgw_pkg::PW+1)'(t_q);
	assign mq_sum = rgw_pkg::RW'(prod) + rgw_pkg::RW'(t_q >>> 16);
	assign half_p = rgw_pkg::AW'({1'b0, cell_size, {(rgw_pkg::MAP_W-1){1'b0}}});
	assign x_pos = !rx_q[rgw_pkg::AW-1] && rx_q != '0;
	assign x_neg = rx_q[rgw_pkg::AW-1];
	assign y_pos = !ry_q[rgw_pkg::AW-1] && ry_q != '0;
	assign y_neg = ry_q[rgw_pkg::AW-1];
	assign half_x = x_pos ? half_p : (x_neg ? -half_p : '0);
	assign half_y = y_pos ? half_p : (y_neg ? -half_p : '0);
	assign mx = rx_q + rgw_pkg::AW'(last_pose_x_q);
	assign my = ry_q + rgw_pkg::AW'(last_pose_y_q);
	assign ox = ofs_fn(in_q.cell_row, last_cell_x_q);
	assign oy = ofs_fn(in_q.cell_col, last_cell_y_q);
	assign stripe_x = stripe_fn(mq_r_q[0], mq_r_q[1], x_pos, x_neg);
	assign stripe_y = stripe_fn(mq_r_q[2], mq_r_q[3], y_pos, y_neg);
	assign mq_b = mq_cs_q ? cell_size : cells_per_metre;

	// Starting result of a new transfer: all zero but the jump flag.
	always_comb begin
		res_init = '0;
		res_init.full_reset = (item.opcode == rgw_pkg::OP_UPDATE) && jump;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rgw_pkg::S_IDLE: begin
				if (item_valid) begin
					case (item.opcode)
						rgw_pkg::OP_UPDATE: state_d = jump ? rgw_pkg::S_MOD : rgw_pkg::S_ROT;
						rgw_pkg::OP_PT_CELL, rgw_pkg::OP_PT_MAP: state_d = rgw_pkg::S_ROT;
						rgw_pkg::OP_OFS_MAP, rgw_pkg::OP_OFS_EGO,
						rgw_pkg::OP_CELL_EGO: state_d = rgw_pkg::S_OFS;
						rgw_pkg::OP_OFS_M: state_d = rgw_pkg::S_MQ;
						default: state_d = rgw_pkg::S_DONE;
					endcase
				end
			end
			rgw_pkg::S_ROT: begin
				if (step_q == 4'd4) begin
					case (in_q.opcode)
						rgw_pkg::OP_UPDATE: state_d = rgw_pkg::S_HALF;
						rgw_pkg::OP_PT_CELL, rgw_pkg::OP_PT_MAP: state_d = rgw_pkg::S_POST;
						default: state_d = rgw_pkg::S_FIN;
					endcase
				end
			end
			rgw_pkg::S_HALF: state_d = rgw_pkg::S_MQ;
			rgw_pkg::S_MQ: begin
				if (step_q == {mq_n_q, 1'b0}) begin
					case (in_q.opcode)
						rgw_pkg::OP_UPDATE: begin
							state_d = (mq_n_q == 3'd4) ? rgw_pkg::S_STRIPE : rgw_pkg::S_COMMIT;
						end
						rgw_pkg::OP_PT_CELL: state_d = rgw_pkg::S_ROUND;
						default: state_d = rgw_pkg::S_SAT;
					endcase
				end
			end
			rgw_pkg::S_STRIPE: state_d = rgw_pkg::S_MOD;
			rgw_pkg::S_MOD: begin
				if (mod_rsp.done && mod_sel_q) begin
					state_d = rgw_pkg::S_MQ;
				end
			end
			rgw_pkg::S_COMMIT: state_d = rgw_pkg::S_DONE;
			rgw_pkg::S_POST: begin
				state_d = (in_q.opcode == rgw_pkg::OP_PT_CELL) ? rgw_pkg::S_MQ : rgw_pkg::S_DONE;
			end
			rgw_pkg::S_ROUND: state_d = rgw_pkg::S_DONE;
			rgw_pkg::S_OFS: begin
				case (in_q.opcode)
					rgw_pkg::OP_OFS_MAP: state_d = rgw_pkg::S_DONE;
					rgw_pkg::OP_OFS_EGO: state_d = rgw_pkg::S_ROT;
					default: state_d = rgw_pkg::S_MQ;
				endcase
			end
			rgw_pkg::S_SAT: state_d = rgw_pkg::S_ROT;
			rgw_pkg::S_FIN: state_d = rgw_pkg::S_DONE;
			rgw_pkg::S_DONE: begin
				if (out_free) begin
					state_d = rgw_pkg::S_IDLE;
				end
			end
			default: state_d = rgw_pkg::S_IDLE;
		endcase
	end

	// Operand selection for the shared multiplier and the remainder unit.
	always_comb begin
		item_stall = state_q != rgw_pkg::S_IDLE;
		result_valid = out_valid_q;
		result = out_q;
		mul_a = ux_q;
		mul_b = '0;
		case (state_q)
			rgw_pkg::S_ROT: begin
				mul_a = step_q[0] ? uy_q : ux_q;
				mul_b = (step_q == 4'd1 || step_q == 4'd2) ? rgw_pkg::BW'(last_sin_q)
				                                          : rgw_pkg::BW'(last_cos_q);
			end
			rgw_pkg::S_MQ: begin
				mul_a = mq_a_q[step_q[2:1]];
				mul_b = step_q[0] ? rgw_pkg::BW'({2'b0, mq_b[30:16]})
				                  : rgw_pkg::BW'({1'b0, mq_b[15:0]});
			end
			default: begin
				mul_a = ux_q;
				mul_b = '0;
			end
		endcase
		mod_req.start = (state_q == rgw_pkg::S_MOD) && (step_q == 4'd0);
		mod_req.value = mod_sel_q ? in_q.pose_y : in_q.pose_x;
		mod_req.span = span;
	end

	// Sequencer state and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgw_pkg::S_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				step_q <= '0;
			end else if (state_q == rgw_pkg::S_MOD) begin
				step_q <= mod_rsp.done ? 4'd0 : 4'd1;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// Pose state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pose_x_q <= rgw_pkg::POSE_RST;
			last_pose_y_q <= rgw_pkg::POSE_RST;
			last_cell_x_q <= rgw_pkg::CELL_RST;
			last_cell_y_q <= rgw_pkg::CELL_RST;
			last_cos_q <= rgw_pkg::COS_RST;
			last_sin_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == rgw_pkg::S_MOD && mod_rsp.done) begin
				if (mod_sel_q) begin
					last_pose_y_q <= mod_rsp.rem;
				end else begin
					last_pose_x_q <= mod_rsp.rem;
				end
			end
			if (state_q == rgw_pkg::S_COMMIT) begin
				last_cell_x_q <= rgw_pkg::sat32(mq_r_q[0]);
				last_cell_y_q <= rgw_pkg::sat32(mq_r_q[1]);
				last_cos_q <= in_q.rot_cos;
				last_sin_q <= in_q.rot_sin;
			end
			if (state_q == rgw_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_sel_q <= 1'b0;
		end else if (accept) begin
			mod_sel_q <= 1'b0;
		end else if (state_q == rgw_pkg::S_MOD && mod_rsp.done) begin
			mod_sel_q <= 1'b1;
		end
	end

	// Working registers, one action per sequencer step.
	always_ff @(posedge clk) begin
		case (state_q)
			rgw_pkg::S_IDLE: begin
				if (accept) begin
					in_q <= item;
					res_q <= res_init;
					ux_q <= rgw_pkg::AW'($signed(item.vec_x));
					uy_q <= rgw_pkg::AW'($signed(item.vec_y));
					mq_a_q[0] <= rgw_pkg::AW'($signed(item.vec_x));
					mq_a_q[1] <= rgw_pkg::AW'($signed(item.vec_y));
					mq_n_q <= 3'd2;
					mq_cs_q <= 1'b1;
					rot_map_q <= (item.opcode == rgw_pkg::OP_UPDATE)
					          || (item.opcode == rgw_pkg::OP_PT_CELL)
					          || (item.opcode == rgw_pkg::OP_PT_MAP);
				end
			end
			rgw_pkg::S_ROT: begin
				case (step_q)
					4'd1, 4'd3: t_q <= prod;
					4'd2: rx_q <= rgw_pkg::AW'((rot_map_q ? t_minus_p : t_plus_p) >>> 14);
					4'd4: ry_q <= rgw_pkg::AW'((rot_map_q ? t_plus_p : p_minus_t) >>> 14);
					default: t_q <= t_q;
				endcase
			end
			rgw_pkg::S_HALF: begin
				mq_a_q[0] <= rgw_pkg::AW'(last_pose_x_q) + half_x;
				mq_a_q[1] <= rgw_pkg::AW'(last_pose_x_q) + half_x + rx_q;
				mq_a_q[2] <= rgw_pkg::AW'(last_pose_y_q) + half_y;
				mq_a_q[3] <= rgw_pkg::AW'(last_pose_y_q) + half_y + ry_q;
				mq_n_q <= 3'd4;
				mq_cs_q <= 1'b0;
			end
			rgw_pkg::S_MQ: begin
				// Low partial product first, then the high one completes the sum.
				if (step_q != 4'd0) begin
					if (!step_m1[0]) begin
						t_q <= prod;
					end else begin
						mq_r_q[step_m1[2:1]] <= mq_sum;
					end
				end
			end
			rgw_pkg::S_STRIPE: begin
				res_q.row_stripe_start <= stripe_x.start;
				res_q.row_stripe_count <= stripe_x.count;
				res_q.row_stripe_down <= stripe_x.down;
				res_q.col_stripe_start <= stripe_y.start;
				res_q.col_stripe_count <= stripe_y.count;
				res_q.col_stripe_down <= stripe_y.down;
			end
			rgw_pkg::S_MOD: begin
				if (mod_rsp.done && mod_sel_q) begin
					mq_a_q[0] <= rgw_pkg::AW'(last_pose_x_q);
					mq_a_q[1] <= rgw_pkg::AW'(mod_rsp.rem);
					mq_n_q <= 3'd2;
					mq_cs_q <= 1'b0;
				end
			end
			rgw_pkg::S_POST: begin
				res_q.result_x <= mx[31:0];
				res_q.result_y <= my[31:0];
				mq_a_q[0] <= mx;
				mq_a_q[1] <= my;
				mq_n_q <= 3'd2;
				mq_cs_q <= 1'b0;
			end
			rgw_pkg::S_ROUND: begin
				res_q.result_x <= round_wrap(mq_r_q[0]);
				res_q.result_y <= round_wrap(mq_r_q[1]);
			end
			rgw_pkg::S_OFS: begin
				res_q.result_x <= ox[31:0];
				res_q.result_y <= oy[31:0];
				ux_q <= rgw_pkg::AW'(ox);
				uy_q <= rgw_pkg::AW'(oy);
				mq_a_q[0] <= rgw_pkg::AW'(ox);
				mq_a_q[1] <= rgw_pkg::AW'(oy);
				mq_n_q <= 3'd2;
				mq_cs_q <= 1'b1;
				rot_map_q <= 1'b0;
			end
			rgw_pkg::S_SAT: begin
				ux_q <= rgw_pkg::AW'(rgw_pkg::sat32(mq_r_q[0]));
				uy_q <= rgw_pkg::AW'(rgw_pkg::sat32(mq_r_q[1]));
				rot_map_q <= 1'b0;
			end
			rgw_pkg::S_FIN: begin
				res_q.result_x <= rx_q[31:0];
				res_q.result_y <= ry_q[31:0];
			end
			rgw_pkg::S_DONE: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// The remainder unit is only started and only answers during the modulo phase.
	a_mod_start: assert property (@(posedge clk) disable iff (!arst_n)
		mod_req.start |-> state_q == rgw_pkg::S_MOD)
		else $error("remainder unit started outside the modulo phase");

	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> state_q == rgw_pkg::S_MOD)
		else $error("remainder unit answered outside the modulo phase");

	// The product batch never runs past its last partial product.
	a_mq_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rgw_pkg::S_MQ |-> step_q <= {mq_n_q, 1'b0})
		else $error("product batch step overran");

	// A map jump never reports stripes.
	a_full_no_stripe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgw_pkg::S_DONE && res_q.full_reset) |->
		(res_q.row_stripe_count == '0 && res_q.col_stripe_count == '0))
		else $error("stripe reported together with a full reset");

	// A finished item reaches the output register once it is free.
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgw_pkg::S_DONE && out_free) |=> out_valid_q)
		else $error("finished result was not registered");

endmodule

// ===== bench/tb_rolling_grid_window_index.sv =====
module tb_rolling_grid_window_index;
	import rgw_pkg::*;

	// Opcode 7 has no meaning; the block must answer with all fields zero.
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam longint HALF_CELLS = longint'(MAP_SIZE / 2) * 65536;

	// Golden model of the pose keeper plus the queue of predicted answers.
	class pose_scoreboard;
		longint cell_size, cpm;
		longint pose_x, pose_y, cellpos_x, cellpos_y, rcos, rsin;
		result_t answers[$];
		int mismatches;
		int surplus;
		int checked;
		int updates;
		int jumps;

		function new();
			cell_size = CELL_SIZE_RST;
			cpm = CPM_RST;
			pose_x = clamp32(longint'(MAP_SIZE / 2) * cell_size);
			pose_y = pose_x;
			cellpos_x = HALF_CELLS;
			cellpos_y = HALF_CELLS;
			rcos = 16384;
			rsin = 0;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// Floor of a * b / 2^16 split into halves so that nothing overflows.
		function longint mul_q16(longint a, longint b);
			longint bh, bl;
			bh = b >>> 16;
			bl = b & 64'hFFFF;
			return a * bh + ((a * bl) >>> 16);
		endfunction

		function longint wrap_idx(longint v);
			longint r;
			r = v % MAP_SIZE;
			return (r < 0) ? r + MAP_SIZE : r;
		endfunction

		// Rows or columns uncovered by a move along one map axis.
		function stripe_t uncovered(longint last, longint dmap);
			stripe_t s;
			longint half, b, e, d, cnt;
			int sg;
			sg = (dmap > 0) ? 1 : ((dmap < 0) ? -1 : 0);
			half = longint'(MAP_SIZE / 2) * cell_size * sg;
			b = mul_q16(last + half, cpm) >>> 16;
			e = mul_q16(last + dmap + half, cpm) >>> 16;
			d = e - b;
			cnt = 0;
			if (sg > 0 && d > 0) cnt = d;
			if (sg < 0 && d < 0) cnt = -d;
			if (cnt > MAP_SIZE) cnt = MAP_SIZE;
			s = '0;
			if (cnt > 0) begin
				s.start = 11'(wrap_idx(b));
				s.count = 12'(cnt);
				s.down = (sg < 0);
			end
			return s;
		endfunction

		function longint cell_offset(logic [10:0] idx, longint lastc);
			longint v;
			v = longint'(idx) * 65536 - lastc;
			if (v > HALF_CELLS) v -= longint'(MAP_SIZE) * 65536;
			else if (v < -HALF_CELLS) v += longint'(MAP_SIZE) * 65536;
			return v;
		endfunction

		function longint round_cells(longint q);
			if (q >= 0) return (q + 32768) >>> 16;
			return -((-q + 32768) >>> 16);
		endfunction

		// Map-axis vector into ego axes through the transposed rotation.
		function void into_ego(longint ix, longint iy, output longint ex, output longint ey);
			ex = (rcos * ix + rsin * iy) >>> 14;
			ey = (rcos * iy - rsin * ix) >>> 14;
		endfunction

		function void write_reg(logic [0:0] idx, logic [31:0] val);
			if (idx == REG_CELL_SIZE) cell_size = val[30:0];
			else cpm = val[30:0];
		endfunction

		// Work out the answer for one accepted transfer and queue it.
		function void note_item(item_t it);
			result_t r;
			stripe_t sr, sc;
			longint vx, vy, rx, ry, spn, dmx, dmy, px, py, ox, oy;
			vx = $signed(it.vec_x);
			vy = $signed(it.vec_y);
			rx = 0;
			ry = 0;
			r = '0;
			case (it.opcode)
				OP_UPDATE: begin
					updates++;
					spn = longint'(MAP_SIZE) * cell_size;
					if (vx > spn || -vx > spn || vy > spn || -vy > spn) begin
						r.full_reset = 1'b1;
						jumps++;
					end else begin
						dmx = (rcos * vx - rsin * vy) >>> 14;
						dmy = (rsin * vx + rcos * vy) >>> 14;
						sr = uncovered(pose_x, dmx);
						sc = uncovered(pose_y, dmy);
						r.row_stripe_start = sr.start;
						r.row_stripe_count = sr.count;
						r.row_stripe_down = sr.down;
						r.col_stripe_start = sc.start;
						r.col_stripe_count = sc.count;
						r.col_stripe_down = sc.down;
					end
					px = $signed(it.pose_x);
					py = $signed(it.pose_y);
					if (spn > 0) begin
						px = px % spn;
						if (px < 0) px += spn;
						py = py % spn;
						if (py < 0) py += spn;
					end else begin
						px = 0;
						py = 0;
					end
					pose_x = clamp32(px);
					pose_y = clamp32(py);
					cellpos_x = clamp32(mul_q16(pose_x, cpm));
					cellpos_y = clamp32(mul_q16(pose_y, cpm));
					rcos = $signed(it.rot_cos);
					rsin = $signed(it.rot_sin);
				end
				OP_PT_CELL, OP_PT_MAP: begin
					rx = ((rcos * vx - rsin * vy) >>> 14) + pose_x;
					ry = ((rsin * vx + rcos * vy) >>> 14) + pose_y;
					if (it.opcode == OP_PT_CELL) begin
						rx = wrap_idx(round_cells(mul_q16(rx, cpm)));
						ry = wrap_idx(round_cells(mul_q16(ry, cpm)));
					end
				end
				OP_OFS_MAP, OP_OFS_EGO, OP_CELL_EGO: begin
					ox = cell_offset(it.cell_row, cellpos_x);
					oy = cell_offset(it.cell_col, cellpos_y);
					if (it.opcode == OP_OFS_MAP) begin
						rx = ox;
						ry = oy;
					end else if (it.opcode == OP_OFS_EGO) begin
						into_ego(ox, oy, rx, ry);
					end else begin
						into_ego(clamp32(mul_q16(ox, cell_size)),
							clamp32(mul_q16(oy, cell_size)), rx, ry);
					end
				end
				OP_OFS_M: begin
					into_ego(clamp32(mul_q16(vx, cell_size)),
						clamp32(mul_q16(vy, cell_size)), rx, ry);
				end
				default: begin
				end
			endcase
			r.result_x = 32'(rx);
			r.result_y = 32'(ry);
			answers.push_back(r);
		endfunction

		// Compare one result transfer with the oldest prediction.
		function void check_result(result_t got);
			result_t want;
			if (answers.size() == 0) begin
				surplus++;
				if (mismatches + surplus <= 10)
					$display("unexpected result transfer: %h", got);
				return;
			end
			want = answers.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch %0d at %0t:", mismatches, $realtime);
					$display("  x  exp %h got %h   y exp %h got %h",
						want.result_x, got.result_x, want.result_y, got.result_y);
					$display("  rows exp %h/%h/%b got %h/%h/%b",
						want.row_stripe_start, want.row_stripe_count, want.row_stripe_down,
						got.row_stripe_start, got.row_stripe_count, got.row_stripe_down);
					$display("  cols exp %h/%h/%b got %h/%h/%b  full exp %b got %b",
						want.col_stripe_start, want.col_stripe_count, want.col_stripe_down,
						got.col_stripe_start, got.col_stripe_count, got.col_stripe_down,
						want.full_reset, got.full_reset);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pose_scoreboard board;
	bit calm;
	int reg_errors;
	int sent;

	rolling_grid_window_index dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("rolling_grid_window_index verification failed");
		$finish;
	end

	// Random back-pressure on the result side, off during the calm stretch.
	always @(negedge clk) begin
		if (!arst_n || calm) result_stall <= 1'b0;
		else result_stall <= ($urandom_range(99) < 18);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(result);
	end

	// One input transfer, with an occasional gap in front of it.
	task automatic send_item(item_t it);
		if (!calm) begin
			while ($urandom_range(99) < 18) @(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		forever begin
			@(posedge clk);
			if (!item_stall) break;
		end
		board.note_item(it);
		sent++;
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	// Register write in setup and access phases, then a read back.
	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		board.write_reg(idx, val);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[30:0] !== val[30:0]) begin
			reg_errors++;
			$display("register %0d read back %h, wrote %h", idx, prdata, val);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Let every predicted answer drain, then give the sequencer time to settle.
	task automatic drain();
		while (board.answers.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic item_t blank_item(logic [2:0] op);
		item_t it;
		it = '0;
		it.opcode = op;
		it.rot_cos = 16'sd16384;
		return it;
	endfunction

	function automatic logic [15:0] rand_rot();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	function automatic logic [31:0] rand_vec();
		if ($urandom_range(9) == 0) return $urandom;
		return 32'($signed($urandom) >>> $urandom_range(31, 6));
	endfunction

	// Mostly pose updates and lookups with random content.
	function automatic item_t rand_item();
		item_t it;
		int pick;
		it = blank_item(OP_UPDATE);
		pick = $urandom_range(99);
		if (pick < 35) it.opcode = OP_UPDATE;
		else if (pick < 97) it.opcode = 3'($urandom_range(6, 1));
		else it.opcode = OP_UNUSED;
		it.vec_x = rand_vec();
		it.vec_y = rand_vec();
		it.pose_x = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(32'h0FFFFFFF));
		it.pose_y = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(32'h0FFFFFFF));
		it.rot_cos = rand_rot();
		it.rot_sin = rand_rot();
		it.cell_row = 11'($urandom);
		it.cell_col = 11'($urandom);
		return it;
	endfunction

	task automatic directed_items();
		item_t it;
		logic [2:0] op;
		// Standing still, then a small move, at the reset pose.
		it = blank_item(OP_UPDATE);
		send_item(it);
		it.vec_x = 32'sd65536;
		it.vec_y = -32'sd200000;
		it.pose_x = 32'sd1000000;
		it.pose_y = 32'sd2000000;
		send_item(it);
		// Jumps beyond the span at both extremes, and exactly the span.
		it.vec_x = 32'sh7FFFFFFF;
		it.vec_y = 32'sh80000000;
		it.pose_x = 32'sh80000000;
		it.pose_y = 32'sh7FFFFFFF;
		it.rot_cos = -16'sd16384;
		it.rot_sin = 16'sd0;
		send_item(it);
		it.vec_x = 32'(2048 * 6554);
		it.vec_y = -32'(2048 * 6554);
		it.rot_cos = 16'sd0;
		it.rot_sin = 16'sd16384;
		send_item(it);
		it.vec_x = 32'(2048 * 6554 + 1);
		it.vec_y = 32'sd0;
		it.rot_sin = -16'sd16384;
		send_item(it);
		// Every lookup at the field extremes.
		for (op = OP_PT_CELL; op <= OP_UNUSED; op++) begin
			it = blank_item(op);
			it.vec_x = 32'sh7FFFFFFF;
			it.vec_y = 32'sh80000000;
			it.cell_row = 11'd2047;
			it.cell_col = 11'd0;
			send_item(it);
			it.vec_x = 32'sh80000000;
			it.vec_y = -32'sd32768;
			it.cell_row = 11'd0;
			it.cell_col = 11'd2047;
			send_item(it);
			if (op == OP_UNUSED) break;
		end
	endtask

	task automatic random_items(int count);
		repeat (count) send_item(rand_item());
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		reg_errors = 0;
		sent = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_items();
		random_items(300);
		calm = 1'b1;
		random_items(200);
		calm = 1'b0;
		drain();

		// Finest grid with the largest reciprocal.
		write_reg(REG_CELL_SIZE, 32'd1);
		write_reg(REG_CPM, 32'h7FFFFFFF);
		directed_items();
		random_items(180);
		drain();

		// Coarsest grid with the smallest reciprocal.
		write_reg(REG_CELL_SIZE, 32'h7FFFFFFF);
		write_reg(REG_CPM, 32'd1);
		directed_items();
		random_items(180);
		drain();

		// One-metre cells, then a random pair drawn independently of each other.
		write_reg(REG_CELL_SIZE, 32'd65536);
		write_reg(REG_CPM, 32'd65536);
		random_items(180);
		drain();
		write_reg(REG_CELL_SIZE, 32'($urandom_range(32'h7FFFFFFF, 1)));
		write_reg(REG_CPM, 32'($urandom_range(32'h7FFFFFFF, 1)));
		random_items(150);
		drain();

		$display("sent %0d items, checked %0d results, %0d pose updates (%0d jumps)",
			sent, board.checked, board.updates, board.jumps);
		$display("covered five register settings including both extremes");
		if (board.mismatches == 0 && board.surplus == 0 && reg_errors == 0
				&& board.answers.size() == 0) begin
			$display("rolling_grid_window_index verification clean");
		end else begin
			$display("%0d mismatches, %0d unexpected, %0d register errors",
				board.mismatches, board.surplus, reg_errors);
			$display("rolling_grid_window_index verification failed");
		end
		$finish;
	end

endmodule
